// ===== rtl/ffa_pkg.sv =====
// Shared types and codes for the first-fit free-list allocator.
// Holds the status and function codes and the pool memory request type.
// No dependencies.
package ffa_pkg;

    // Operation codes carried on func.
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // Status codes carried on status.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Block layout constants in bytes.
    localparam logic [31:0] HDR_BYTES  = 32'd4;
    localparam logic [31:0] FREE_BIT   = 32'd1;
    localparam logic [16:0] MIN_POOL   = 17'd32;
    localparam logic [31:0] HEAD_OFS   = 32'd8;

    // One 32-bit access at an arbitrary byte offset of the pool.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [31:0] addr;
        logic [31:0] wdata;
    } mem_req_t;

endpackage

// ===== rtl/ffa_mem.sv =====
// Pool memory: four byte-wide banks, one 32-bit access per cycle at any byte offset.
// Byte offsets wrap modulo the pool size; read data is registered and arrives in the cycle after the request.
// Depends on ffa_pkg.
module ffa_mem #(
    parameter int POOL_WORDS = 16384
) (
    input  logic             clk,
    input  ffa_pkg::mem_req_t req,
    output logic [31:0]      rdata
);
    import ffa_pkg::*;

    localparam int WAW = $clog2(POOL_WORDS);
    localparam int BAW = WAW + 2;
    localparam logic [32:0] PoolBytes = 33'(POOL_WORDS) << 2;
    localparam bit POW2 = ((POOL_WORDS & (POOL_WORDS - 1)) == 0);

    logic [1:0] a0_reg;
    logic [7:0] rbyte_reg [4];

    // Lane offset of the request, kept for assembling the read data.
    always_ff @(posedge clk)
    begin
        if (req.en && !req.we)
        begin
            a0_reg <= req.addr[1:0];
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [7:0]     mem [POOL_WORDS];
        logic [1:0]     lane;
        logic [32:0]    ext;
        logic [BAW-1:0] boff;
        logic [WAW-1:0] idx;

        // Byte of the word that falls into this bank, and its wrapped location.
        always_comb
        begin
            lane = 2'(2'(k) - req.addr[1:0]);
            ext  = {1'b0, req.addr} + 33'(lane);
            if (POW2)
            begin
                boff = ext[BAW-1:0];
            end
            else
            begin
                boff = BAW'(ext % PoolBytes);
            end
            idx = boff[BAW-1:2];
        end

        // Synchronous bank with a registered read.
        always_ff @(posedge clk)
        begin
            if (req.en)
            begin
                if (req.we)
                begin
                    mem[idx] <= req.wdata[8*lane +: 8];
                end
                else
                begin
                    rbyte_reg[k] <= mem[idx];
                end
            end
        end
    end

    // Reorder the bank bytes into little-endian word order.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rdata[8*i +: 8] = rbyte_reg[2'(a0_reg + 2'(i))];
        end
    end

endmodule

// ===== rtl/first_fit_free_list_allocator_core.sv =====
// First-fit free-list allocator with coalescing over a byte pool in one memory.
// An alloc walks the free list node by node; a free answers a bad offset with a range
// status, else inserts the block in address order and merges it with its neighbours.
// One request at a time: the next request is taken at the earliest in the cycle after
// the result is loaded, and a finished result waits in the output register.
// Reset and each pool_size write rebuild the list while the input is not ready.
module first_fit_free_list_allocator_core #(
    parameter int POOL_WORDS = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [16:0] req_size,
    input  logic [16:0] free_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_addr,
    output logic [1:0]  status
);
    import ffa_pkg::*;

    localparam int SW = $clog2(POOL_WORDS + 1);
    localparam logic [32:0] PoolBytes = 33'(POOL_WORDS) << 2;

    localparam logic [4:0] S_INIT0 = 5'd0;
    localparam logic [4:0] S_INIT1 = 5'd1;
    localparam logic [4:0] S_IDLE  = 5'd2;
    localparam logic [4:0] A_CHK   = 5'd3;
    localparam logic [4:0] A_RSZ   = 5'd4;
    localparam logic [4:0] A_RNX   = 5'd5;
    localparam logic [4:0] A_SPL1  = 5'd6;
    localparam logic [4:0] A_SPL2  = 5'd7;
    localparam logic [4:0] A_SPL3  = 5'd8;
    localparam logic [4:0] A_TAKE  = 5'd9;
    localparam logic [4:0] A_LINK  = 5'd10;
    localparam logic [4:0] F_RDH   = 5'd11;
    localparam logic [4:0] F_WRH   = 5'd12;
    localparam logic [4:0] F_HEAD  = 5'd13;
    localparam logic [4:0] F_RD    = 5'd14;
    localparam logic [4:0] F_NX    = 5'd15;
    localparam logic [4:0] F_W2    = 5'd16;
    localparam logic [4:0] M_R0    = 5'd17;
    localparam logic [4:0] M_R1    = 5'd18;
    localparam logic [4:0] M_R2    = 5'd19;
    localparam logic [4:0] M_R3    = 5'd20;
    localparam logic [4:0] M_R4    = 5'd21;
    localparam logic [4:0] M_R5    = 5'd22;
    localparam logic [4:0] S_DONE  = 5'd23;

    logic [4:0]    state_reg, state_next;
    logic [16:0]   psize_reg, psize_next;
    logic [31:0]   ff_reg, ff_next;
    logic [17:0]   req_reg, req_next;
    logic [31:0]   cur_reg, cur_next;
    logic [31:0]   prev_reg, prev_next;
    logic          hp_reg, hp_next;
    logic          first_reg, first_next;
    logic          ph2_reg, ph2_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [31:0]   sz_reg, sz_next;
    logic [31:0]   nx_reg, nx_next;
    logic [31:0]   nb_reg, nb_next;
    logic [31:0]   mb_reg, mb_next;
    logic [31:0]   tmp_reg, tmp_next;
    logic [31:0]   lv_reg, lv_next;
    logic [15:0]   raddr_reg, raddr_next;
    logic [1:0]    rst_reg, rst_next;
    logic          ovld_reg, ovld_next;
    logic [15:0]   oaddr_reg, oaddr_next;
    logic [1:0]    ost_reg, ost_next;

    mem_req_t    mreq;
    logic [31:0] mrdata;
    logic [16:0] pend;
    logic [32:0] pclamp;
    logic [17:0] req_round;
    logic [31:0] req32;
    logic        in_xfer;
    logic        fit_split;
    logic        fit_whole;
    logic        merge_ok;

    ffa_mem #(
        .POOL_WORDS(POOL_WORDS)
    ) u_mem (
        .clk  (clk),
        .req  (mreq),
        .rdata(mrdata)
    );

    // Effective pool end: pool_size clamped to the supported range.
    always_comb
    begin
        pclamp = {16'd0, psize_reg};
        if (psize_reg < MIN_POOL)
        begin
            pclamp = {16'd0, MIN_POOL};
        end
        else if (pclamp > PoolBytes)
        begin
            pclamp = PoolBytes;
        end
        pend = pclamp[16:0];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign req_round = ({1'b0, req_size} + 18'd7) & ~18'd7;
    assign req32     = 32'(req_reg);

    // Fit tests of the node in hand against the rounded request.
    assign fit_split = ((sz_reg - 32'd1) > (req32 + HDR_BYTES))
        && ((34'(cur_reg) + 34'(req_reg) + 34'd12) < 34'(pend));
    assign fit_whole = ((sz_reg - 32'd1) >= req32);
    assign merge_ok  = (ph2_reg || (nx_reg != 32'd0))
        && (nx_reg == mb_reg + mrdata + 32'd3);

    // Control sequencer: every pool access goes through the single memory port.
    always_comb
    begin
        state_next = state_reg;
        psize_next = psize_reg;
        ff_next    = ff_reg;
        req_next   = req_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        hp_next    = hp_reg;
        first_next = first_reg;
        ph2_next   = ph2_reg;
        steps_next = steps_reg;
        sz_next    = sz_reg;
        nx_next    = nx_reg;
        nb_next    = nb_reg;
        mb_next    = mb_reg;
        tmp_next   = tmp_reg;
        lv_next    = lv_reg;
        raddr_next = raddr_reg;
        rst_next   = rst_reg;
        mreq       = '0;

        unique case (state_reg)
            S_INIT0:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: HEAD_OFS,
                         wdata: 32'(pend) - 32'd11};
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: HEAD_OFS + HDR_BYTES, wdata: 32'd0};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    hp_next    = 1'b0;
                    prev_next  = 32'd0;
                    steps_next = '0;
                    raddr_next = 16'd0;
                    rst_next   = ST_OK;
                    if (func == FN_ALLOC)
                    begin
                        req_next   = req_round;
                        cur_next   = ff_reg;
                        state_next = A_CHK;
                    end
                    else if (free_addr < 17'd4 || free_addr > pend)
                    begin
                        rst_next   = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        nb_next    = 32'(free_addr) - HDR_BYTES;
                        state_next = F_RDH;
                    end
                end
            end
            A_CHK:
            begin
                if (cur_reg == 32'd0 || steps_reg == SW'(POOL_WORDS))
                begin
                    rst_next   = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    mreq = '{en: 1'b1, we: 1'b0, addr: cur_reg, wdata: 32'd0};
                    state_next = A_RSZ;
                end
            end
            A_RSZ:
            begin
                sz_next = mrdata;
                mreq = '{en: 1'b1, we: 1'b0, addr: cur_reg + HDR_BYTES, wdata: 32'd0};
                state_next = A_RNX;
            end
            A_RNX:
            begin
                nx_next = mrdata;
                if (fit_split)
                begin
                    tmp_next = cur_reg + req32 + HDR_BYTES;
                    lv_next  = cur_reg + req32 + HDR_BYTES;
                    if (ff_reg == cur_reg)
                    begin
                        ff_next = cur_reg + req32 + HDR_BYTES;
                    end
                    state_next = A_SPL1;
                end
                else if (fit_whole)
                begin
                    lv_next = mrdata;
                    if (ff_reg == cur_reg)
                    begin
                        ff_next = mrdata;
                    end
                    state_next = A_TAKE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    hp_next    = 1'b1;
                    cur_next   = mrdata;
                    steps_next = steps_reg + SW'(1);
                    state_next = A_CHK;
                end
            end
            A_SPL1:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: tmp_reg,
                         wdata: sz_reg - req32 - HDR_BYTES};
                state_next = A_SPL2;
            end
            A_SPL2:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: cur_reg, wdata: req32};
                state_next = A_SPL3;
            end
            A_SPL3:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: tmp_reg + HDR_BYTES, wdata: nx_reg};
                raddr_next = 16'(cur_reg + HDR_BYTES);
                state_next = hp_reg ? A_LINK : S_DONE;
            end
            A_TAKE:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: cur_reg, wdata: sz_reg - 32'd1};
                raddr_next = 16'(cur_reg + HDR_BYTES);
                state_next = hp_reg ? A_LINK : S_DONE;
            end
            A_LINK:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: prev_reg + HDR_BYTES, wdata: lv_reg};
                state_next = S_DONE;
            end
            F_RDH:
            begin
                mreq = '{en: 1'b1, we: 1'b0, addr: nb_reg, wdata: 32'd0};
                state_next = F_WRH;
            end
            F_WRH:
            begin
                // Mark the block free, then find where it goes in the list.
                mreq = '{en: 1'b1, we: 1'b1, addr: nb_reg, wdata: mrdata + FREE_BIT};
                if (ff_reg == 32'd0 || nb_reg < ff_reg)
                begin
                    state_next = F_HEAD;
                end
                else
                begin
                    cur_next   = ff_reg;
                    first_next = 1'b1;
                    state_next = F_RD;
                end
            end
            F_HEAD:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: nb_reg + HDR_BYTES, wdata: ff_reg};
                ff_next    = nb_reg;
                mb_next    = nb_reg;
                ph2_next   = 1'b0;
                state_next = M_R0;
            end
            F_RD:
            begin
                if (steps_reg == SW'(POOL_WORDS))
                begin
                    mb_next    = nb_reg;
                    ph2_next   = 1'b0;
                    state_next = M_R0;
                end
                else
                begin
                    mreq = '{en: 1'b1, we: 1'b0, addr: cur_reg + HDR_BYTES, wdata: 32'd0};
                    state_next = F_NX;
                end
            end
            F_NX:
            begin
                mb_next  = nb_reg;
                ph2_next = 1'b0;
                if (mrdata == 32'd0)
                begin
                    state_next = M_R0;
                    if (nb_reg > cur_reg)
                    begin
                        // Append after the last free node.
                        mreq = '{en: 1'b1, we: 1'b1, addr: cur_reg + HDR_BYTES,
                                 wdata: nb_reg};
                        tmp_next   = nb_reg + HDR_BYTES;
                        lv_next    = 32'd0;
                        prev_next  = cur_reg;
                        hp_next    = 1'b1;
                        state_next = F_W2;
                    end
                    else if (first_reg)
                    begin
                        // Block equals the only listed node.
                        mreq = '{en: 1'b1, we: 1'b1, addr: nb_reg + HDR_BYTES,
                                 wdata: cur_reg};
                        ff_next = nb_reg;
                    end
                end
                else if (nb_reg > cur_reg && nb_reg < mrdata)
                begin
                    mreq = '{en: 1'b1, we: 1'b1, addr: nb_reg + HDR_BYTES, wdata: mrdata};
                    tmp_next   = cur_reg + HDR_BYTES;
                    lv_next    = nb_reg;
                    prev_next  = cur_reg;
                    hp_next    = 1'b1;
                    state_next = F_W2;
                end
                else
                begin
                    cur_next   = mrdata;
                    first_next = 1'b0;
                    steps_next = steps_reg + SW'(1);
                    state_next = F_RD;
                end
            end
            F_W2:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: tmp_reg, wdata: lv_reg};
                state_next = M_R0;
            end
            M_R0:
            begin
                mreq = '{en: 1'b1, we: 1'b0, addr: mb_reg + HDR_BYTES, wdata: 32'd0};
                state_next = M_R1;
            end
            M_R1:
            begin
                nx_next = mrdata;
                mreq = '{en: 1'b1, we: 1'b0, addr: mb_reg, wdata: 32'd0};
                state_next = M_R2;
            end
            M_R2:
            begin
                sz_next = mrdata;
                if (merge_ok)
                begin
                    mreq = '{en: 1'b1, we: 1'b0, addr: nx_reg, wdata: 32'd0};
                    state_next = M_R3;
                end
                else if (!ph2_reg && hp_reg)
                begin
                    mb_next    = prev_reg;
                    ph2_next   = 1'b1;
                    state_next = M_R0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            M_R3:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: mb_reg,
                         wdata: sz_reg + mrdata + 32'd3};
                state_next = M_R4;
            end
            M_R4:
            begin
                mreq = '{en: 1'b1, we: 1'b0, addr: nx_reg + HDR_BYTES, wdata: 32'd0};
                state_next = M_R5;
            end
            M_R5:
            begin
                mreq = '{en: 1'b1, we: 1'b1, addr: mb_reg + HDR_BYTES, wdata: mrdata};
                if (!ph2_reg && hp_reg)
                begin
                    mb_next    = prev_reg;
                    ph2_next   = 1'b1;
                    state_next = M_R0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A pool_size write rebuilds the free list.
        if (cfg_we)
        begin
            psize_next = cfg_wdata;
            ff_next    = HEAD_OFS;
            state_next = S_INIT0;
        end
    end

    // Output register: loads the finished result, holds it until the transfer.
    always_comb
    begin
        ovld_next  = ovld_reg;
        oaddr_next = oaddr_reg;
        ost_next   = ost_reg;
        if (out_valid && out_ready)
        begin
            ovld_next = 1'b0;
        end
        if (state_reg == S_DONE && (!ovld_reg || out_ready))
        begin
            ovld_next  = 1'b1;
            oaddr_next = raddr_reg;
            ost_next   = rst_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT0;
            psize_reg <= 17'h10000;
            ff_reg    <= HEAD_OFS;
            ovld_reg  <= 1'b0;
            hp_reg    <= 1'b0;
            first_reg <= 1'b0;
            ph2_reg   <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            psize_reg <= psize_next;
            ff_reg    <= ff_next;
            ovld_reg  <= ovld_next;
            hp_reg    <= hp_next;
            first_reg <= first_next;
            ph2_reg   <= ph2_next;
            steps_reg <= steps_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        sz_reg    <= sz_next;
        nx_reg    <= nx_next;
        nb_reg    <= nb_next;
        mb_reg    <= mb_next;
        tmp_reg   <= tmp_next;
        lv_reg    <= lv_next;
        raddr_reg <= raddr_next;
        rst_reg   <= rst_next;
        oaddr_reg <= oaddr_next;
        ost_reg   <= ost_next;
    end

    assign out_valid   = ovld_reg;
    assign result_addr = oaddr_reg;
    assign status      = ost_reg;

    // One request at a time: no new transfer right after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a request is in progress");

    // A failed or rejected request carries no offset.
    a_null_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOFIT || status == ST_RANGE) |-> result_addr == 16'd0)
        else $error("error result carries a nonzero offset");

    // The walk bound is never exceeded.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= SW'(POOL_WORDS))
        else $error("list walk ran past its bound");

    // A loaded result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
        else $error("pending result lost");

endmodule

// ===== tb/ffa_checker.sv =====
// Scoreboard for the first-fit allocator: it watches configuration, request and result
// transfers, keeps its own copy of the pool and free list, and compares every result.
// Depends on ffa_pkg for the operation and status codes.
module ffa_checker #(
    parameter int POOL_WORDS = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [16:0] req_size,
    input  logic [16:0] free_addr,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] result_addr,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending
);
    import ffa_pkg::*;

    localparam int POOL_BYTES = POOL_WORDS * 4;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  code;
    } grant_t;

    // Shadow of the pool, the list head and the usable pool end.
    logic [31:0] shadow_pool [POOL_WORDS];
    logic [31:0] list_head;
    logic [31:0] pool_end;
    grant_t      awaited [$];

    function automatic logic [7:0] byte_rd(input logic [31:0] a);
        int b;
        b = a % POOL_BYTES;
        return shadow_pool[b / 4][(b % 4) * 8 +: 8];
    endfunction

    function automatic void byte_wr(input logic [31:0] a, input logic [7:0] v);
        int b;
        b = a % POOL_BYTES;
        shadow_pool[b / 4][(b % 4) * 8 +: 8] = v;
    endfunction

    // Little-endian word access at any byte offset, wrapping around the pool.
    function automatic logic [31:0] word_rd(input logic [31:0] a);
        logic [31:0] v;
        for (int i = 0; i < 4; i++)
            v[i * 8 +: 8] = byte_rd(a + i);
        return v;
    endfunction

    function automatic void word_wr(input logic [31:0] a, input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            byte_wr(a + i, v[i * 8 +: 8]);
    endfunction

    // Rebuild the list as one free block after the head area.
    function automatic void rebuild_list(input logic [16:0] size);
        logic [31:0] p;
        p = size;
        if (p < 32) p = 32;
        if (p > POOL_BYTES) p = POOL_BYTES;
        pool_end  = p;
        list_head = 32'd8;
        word_wr(32'd8, p - 32'd11);
        word_wr(32'd12, 32'd0);
    endfunction

    // First-fit allocation with split when the remainder can hold a free header.
    function automatic logic [1:0] predict_alloc(input logic [31:0] req,
                                                 output logic [31:0] grant);
        logic [31:0] cur, prev, sz, nx, nf;
        bit          has_prev;
        cur = list_head;
        prev = 0;
        has_prev = 0;
        grant = 0;
        if (req % 8 != 0) req = req + 8 - req % 8;
        for (int steps = 0; cur != 0 && steps < POOL_WORDS; steps++)
        begin
            sz = word_rd(cur);
            nx = word_rd(cur + 32'd4);
            if ((sz - 32'd1 > req + 32'd4) &&
                ({32'b0, cur} + 64'd12 + {32'b0, req} < {32'b0, pool_end}))
            begin
                nf = cur + req + 32'd4;
                word_wr(nf, sz - req - 32'd4);
                word_wr(cur, req);
                word_wr(nf + 32'd4, nx);
                if (list_head == cur) list_head = nf;
                if (has_prev) word_wr(prev + 32'd4, nf);
                grant = cur + 32'd4;
                return ST_OK;
            end
            else if (sz - 32'd1 >= req)
            begin
                word_wr(cur, sz - 32'd1);
                if (list_head == cur) list_head = nx;
                if (has_prev) word_wr(prev + 32'd4, nx);
                grant = cur + 32'd4;
                return ST_OK;
            end
            prev = cur;
            has_prev = 1;
            cur = nx;
        end
        return ST_NOFIT;
    endfunction

    // Address-ordered insert followed by merges with the next and previous blocks.
    function automatic logic [1:0] predict_free(input logic [31:0] addr);
        logic [31:0] nb, cur, prev, nx, pn;
        bit          has_prev;
        prev = 0;
        has_prev = 0;
        if (addr < 4 || addr > pool_end) return ST_RANGE;
        nb = addr - 32'd4;
        word_wr(nb, word_rd(nb) + 32'd1);
        if (list_head == 0 || nb < list_head)
        begin
            word_wr(nb + 32'd4, list_head);
            list_head = nb;
        end
        else
        begin
            cur = list_head;
            if (word_rd(cur + 32'd4) == 0)
            begin
                if (nb > cur)
                begin
                    word_wr(cur + 32'd4, nb);
                    word_wr(nb + 32'd4, 32'd0);
                    prev = cur;
                    has_prev = 1;
                end
                else
                begin
                    list_head = nb;
                    word_wr(nb + 32'd4, cur);
                end
            end
            else
            begin
                for (int steps = 0; steps < POOL_WORDS; steps++)
                begin
                    nx = word_rd(cur + 32'd4);
                    if (nx == 0)
                    begin
                        // A block past the last free node is appended.
                        if (nb > cur)
                        begin
                            word_wr(cur + 32'd4, nb);
                            word_wr(nb + 32'd4, 32'd0);
                            prev = cur;
                            has_prev = 1;
                        end
                        break;
                    end
                    if (nb > cur && nb < nx)
                    begin
                        word_wr(nb + 32'd4, nx);
                        word_wr(cur + 32'd4, nb);
                        prev = cur;
                        has_prev = 1;
                        break;
                    end
                    cur = nx;
                end
            end
        end
        nx = word_rd(nb + 32'd4);
        if (nx != 0 && nx == nb + word_rd(nb) + 32'd3)
        begin
            word_wr(nb, word_rd(nb) + word_rd(nx) + 32'd3);
            word_wr(nb + 32'd4, word_rd(nx + 32'd4));
        end
        if (has_prev)
        begin
            pn = word_rd(prev + 32'd4);
            if (pn == prev + word_rd(prev) + 32'd3)
            begin
                word_wr(prev, word_rd(prev) + word_rd(pn) + 32'd3);
                word_wr(prev + 32'd4, word_rd(pn + 32'd4));
            end
        end
        return ST_OK;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Compare finished results, then predict newly accepted requests.
    always @(posedge clk or negedge rst_n)
    begin
        grant_t      want;
        logic [31:0] grant;
        logic [1:0]  code;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_WORDS; i++)
                shadow_pool[i] = 32'd0;
            rebuild_list(17'd65536);
            awaited.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
                rebuild_list(cfg_wdata);
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                    report_mismatch($sformatf("unexpected result addr=%0d status=%0d",
                                              result_addr, status));
                else
                begin
                    want = awaited.pop_front();
                    if (result_addr !== want.addr)
                        report_mismatch($sformatf("result_addr %0d, expected %0d",
                                                  result_addr, want.addr));
                    if (status !== want.code)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.code));
                end
            end
            if (in_valid && in_ready)
            begin
                grant = 0;
                if (func == FN_ALLOC)
                    code = predict_alloc({15'b0, req_size}, grant);
                else
                    code = predict_free({15'b0, free_addr});
                want.addr = grant[15:0];
                want.code = code;
                awaited.push_back(want);
            end
            pending = awaited.size();
        end
    end

endmodule

// ===== tb/tb_first_fit_free_list_allocator_core.sv =====
// Testbench top for the first-fit allocator core: drives bursts of allocate and free
// requests over several pool sizes and gives the verdict from ffa_checker.
// Depends on ffa_pkg, ffa_checker and the allocator core.
module tb_first_fit_free_list_allocator_core;
    import ffa_pkg::*;

    localparam int IDLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [16:0] req_size;
    logic [16:0] free_addr;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result_addr;
    logic [1:0]  status;
    int          fail_count;
    int          pending;

    // Payload offsets granted in the current pool setting; a release usually takes one out.
    logic [16:0] live_blocks [$];
    int          pool_bytes;
    int          idle_cycles;
    int          rx_left;
    int          rx_mode;

    first_fit_free_list_allocator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .req_size    (req_size),
        .free_addr   (free_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_addr (result_addr),
        .status      (status)
    );

    ffa_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .req_size    (req_size),
        .free_addr   (free_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_addr (result_addr),
        .status      (status),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side stalls on its own pattern: always ready, random, or mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_left = 0;
            rx_mode = 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(5, 80);
            end
            rx_left--;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Collect granted offsets so that frees target real blocks.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && status == ST_OK && result_addr != 0)
            live_blocks.push_back({1'b0, result_addr});
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one request and hold it until the transfer; valid stays high on return.
    task automatic send_request(input logic fn, input logic [16:0] size,
                                input logic [16:0] offset);
        in_valid  <= 1'b1;
        func      <= fn;
        req_size  <= size;
        free_addr <= offset;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic go_idle(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every result has been taken and recorded.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Rewrite the pool size once the block is idle; old blocks are forgotten.
    task automatic set_pool(input logic [16:0] size);
        drain();
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
        live_blocks.delete();
        pool_bytes = (size < 32) ? 32 : ((size > 65536) ? 65536 : size);
    endtask

    // Random traffic: mostly allocations and releases of live blocks, some noise.
    task automatic random_traffic(input int count);
        int          burst;
        int          pick;
        int          roll;
        logic [16:0] offset;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                go_idle($urandom_range(0, 3) == 0 ? $urandom_range(5, 30)
                                                  : $urandom_range(1, 4));
                burst = $urandom_range(1, 40);
            end
            burst--;
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                // Release outside the pool: below the first header or past its end.
                offset = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 3))
                       : 17'($urandom_range(pool_bytes + 1, 131071));
                send_request(FN_FREE, 17'($urandom), offset);
            end
            else if (roll < 50 && live_blocks.size() != 0)
            begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                offset = live_blocks[pick];
                // Now and then the block stays listed and is released a second time.
                if ($urandom_range(0, 29) != 0)
                    live_blocks.delete(pick);
                send_request(FN_FREE, 17'($urandom), offset);
            end
            else if (roll < 53)
                send_request(FN_ALLOC, 17'($urandom_range(pool_bytes / 2, 65536)),
                             17'($urandom));
            else
                send_request(FN_ALLOC, 17'($urandom_range(0, pool_bytes / 8 + 8)),
                             17'($urandom));
        end
    endtask

    initial
    begin
        logic [16:0] first_three [3];
        idle_cycles = 0;
        pool_bytes  = 65536;
        cfg_we      = 1'b0;
        cfg_wdata   = 17'd0;
        in_valid    = 1'b0;
        func        = FN_ALLOC;
        req_size    = 17'd0;
        free_addr   = 17'd0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size rounding, zero size, oversize requests and bad offsets.
        send_request(FN_ALLOC, 17'd0, 17'd0);
        send_request(FN_ALLOC, 17'd1, 17'd0);
        send_request(FN_ALLOC, 17'd7, 17'd0);
        send_request(FN_ALLOC, 17'd8, 17'd0);
        send_request(FN_ALLOC, 17'd65536, 17'd0);
        send_request(FN_ALLOC, 17'd65520, 17'd0);
        send_request(FN_FREE, 17'd0, 17'd0);
        send_request(FN_FREE, 17'd0, 17'd3);
        send_request(FN_FREE, 17'h1FFFF, 17'h1FFFF);
        drain();
        for (int i = 0; i < 3; i++)
            first_three[i] = live_blocks[i];
        // Release with merge on both sides, a double release, then a large split.
        send_request(FN_FREE, 17'd0, first_three[0]);
        send_request(FN_FREE, 17'd0, first_three[2]);
        send_request(FN_FREE, 17'd0, first_three[1]);
        send_request(FN_FREE, 17'd0, first_three[1]);
        send_request(FN_ALLOC, 17'd40000, 17'd0);
        drain();
        live_blocks.delete();
        random_traffic(240);

        // Smallest pool, values that clamp, and a mid-sized pool.
        set_pool(17'd32);
        send_request(FN_ALLOC, 17'd0, 17'd0);
        send_request(FN_ALLOC, 17'd16, 17'd0);
        send_request(FN_FREE, 17'd0, 17'd33);
        random_traffic(150);
        set_pool(17'd0);
        random_traffic(100);
        set_pool(17'd1000);
        send_request(FN_FREE, 17'd0, 17'd65536);
        random_traffic(250);
        set_pool(17'h1FFFF);
        random_traffic(250);
        set_pool(17'd4096);
        random_traffic(200);

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
